// File: hdl/wfm_pkg.sv
`timescale 1ns / 1ps

package wfm_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COEF_FRAC_BITS = 12;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int TAPS    = 9;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int DATA_W  = 64;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);

    localparam logic [DATA_W-1:0] COEF_WORD_RST = 64'h01C7_01C7_01C7_01C7;
    localparam logic [COEF_W-1:0] COEF_TAP_RST  = 16'h01C7;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column, top row first
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // row-major 3x3 window, entry 0 top-left
    typedef logic [TAPS-1:0][PIX_W-1:0]  t_win;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_taps;

    typedef enum logic [2:0] {
        CFG_FILTER_MODE  = 3'd0,
        CFG_IMAGE_WIDTH  = 3'd1,
        CFG_IMAGE_HEIGHT = 3'd2,
        CFG_COEF_LOW     = 3'd3,
        CFG_COEF_MID     = 3'd4,
        CFG_COEF_HIGH    = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        MODE_CONVOLVE = 1'b0,
        MODE_MEDIAN   = 1'b1
    } t_mode;

endpackage

// File: hdl/wfm_if.sv
`timescale 1ns / 1ps

interface wfm_pixel_if;
    logic                valid;
    logic                ready;
    logic [wfm_pkg::PIX_W-1:0] pixel;

    modport source(output valid, output pixel, input ready);
    modport sink(input valid, input pixel, output ready);
endinterface

interface wfm_result_if;
    logic                        valid;
    logic                        ready;
    logic [wfm_pkg::COORD_W-1:0] out_row;
    logic [wfm_pkg::COORD_W-1:0] out_col;
    logic [wfm_pkg::PIX_W-1:0]   value;
    logic                        frame_last;

    modport source(output valid, output out_row, output out_col, output value,
                   output frame_last, input ready);
    modport sink(input valid, input out_row, input out_col, input value,
                 input frame_last, output ready);
endinterface

// File: hdl/wfm_col_cell.sv
`timescale 1ns / 1ps

module wfm_col_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  wfm_pkg::t_col i_col,
    output wfm_pkg::t_col o_col
);

    wfm_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// File: hdl/wfm_conv.sv
`timescale 1ns / 1ps

module wfm_conv (
    input  logic                        i_clk,
    input  wfm_pkg::t_win               i_win,
    input  wfm_pkg::t_taps              i_taps,
    output logic [wfm_pkg::PIX_W-1:0]   o_value
);

    localparam int PROD_W = wfm_pkg::PIX_W + 1 + wfm_pkg::COEF_W;
    localparam int PART_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int Q_W    = SUM_W - wfm_pkg::COEF_FRAC_BITS;

    logic signed [PROD_W-1:0] r_prod [wfm_pkg::TAPS];
    logic signed [PART_W-1:0] r_part [3];
    logic signed [SUM_W-1:0]  n_sum;
    logic        [Q_W-1:0]    n_q;
    logic [wfm_pkg::PIX_W-1:0] n_value;
    logic [wfm_pkg::PIX_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < wfm_pkg::TAPS; k++) begin
            r_prod[k] <= $signed({1'b0, i_win[k]}) * $signed(i_taps[k]);
        end
        for (int g = 0; g < 3; g++) begin
            r_part[g] <= PART_W'(r_prod[3*g]) + PART_W'(r_prod[3*g+1])
                       + PART_W'(r_prod[3*g+2]);
        end
        r_value <= n_value;
    end

    always_comb begin
        n_sum = SUM_W'(r_part[0]) + SUM_W'(r_part[1]) + SUM_W'(r_part[2]);
        n_q   = n_sum[SUM_W-1:wfm_pkg::COEF_FRAC_BITS];
        // floor, then clip to the pixel range
        if (n_sum[SUM_W-1]) begin
            n_value = '0;
        end else if (|n_q[Q_W-1:wfm_pkg::PIX_W]) begin
            n_value = '1;
        end else begin
            n_value = n_q[wfm_pkg::PIX_W-1:0];
        end
    end

    assign o_value = r_value;

endmodule

// File: hdl/wfm_median.sv
`timescale 1ns / 1ps

module wfm_median (
    input  logic                      i_clk,
    input  wfm_pkg::t_win             i_win,
    output logic [wfm_pkg::PIX_W-1:0] o_value
);

    typedef logic [2:0][wfm_pkg::PIX_W-1:0] t_tri;

    // returns {max, med, min}
    function automatic t_tri sort3(input wfm_pkg::t_pix a, input wfm_pkg::t_pix b,
                                   input wfm_pkg::t_pix c);
        wfm_pkg::t_pix x, y, z, t;
        x = a;
        y = b;
        z = c;
        if (x > y) begin
            t = x; x = y; y = t;
        end
        if (y > z) begin
            t = y; y = z; z = t;
        end
        if (x > y) begin
            t = x; x = y; y = t;
        end
        return {z, y, x};
    endfunction

    t_tri          r_row [3];
    t_tri          n_lo_s, n_mid_s, n_hi_s, n_fin;
    wfm_pkg::t_pix r_lo, r_mid, r_hi, r_value;

    always_comb begin
        n_lo_s  = sort3(r_row[0][0], r_row[1][0], r_row[2][0]);
        n_mid_s = sort3(r_row[0][1], r_row[1][1], r_row[2][1]);
        n_hi_s  = sort3(r_row[0][2], r_row[1][2], r_row[2][2]);
        n_fin   = sort3(r_lo, r_mid, r_hi);
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_row[r] <= sort3(i_win[3*r], i_win[3*r+1], i_win[3*r+2]);
        end
        // largest of the row minima, middle of the medians, smallest of the maxima
        r_lo    <= n_lo_s[2];
        r_mid   <= n_mid_s[1];
        r_hi    <= n_hi_s[0];
        r_value <= n_fin[1];
    end

    assign o_value = r_value;

endmodule

// File: hdl/window_filter_median_or_convolve.sv
`timescale 1ns / 1ps

// 3x3 median or convolution filter over a raster stream of 8-bit pixels, one
// request per clock sustained. Each accepted pixel reads the two line stores
// (one 16-bit wide memory, registered read), the new column enters a chain of
// three column cells forming the window, and the filter result is offered
// through an eight-entry output queue. Input ready drops only
// when eight results are pending, so a slow sink throttles the source and
// never loses a result. Border centres give no result. Writing the width or
// height restarts the frame at row 0, column 0. Line store contents are not
// cleared; the first two rows of each frame refill them before use.
module window_filter_median_or_convolve (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [wfm_pkg::DATA_W-1:0]  i_cfg_data,
    wfm_pixel_if.sink                   i_pix,
    wfm_result_if.source                o_res
);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;
    localparam int LS_W       = 2 * wfm_pkg::PIX_W;

    typedef struct packed {
        logic [wfm_pkg::COORD_W-1:0] row;
        logic [wfm_pkg::COORD_W-1:0] col;
        logic                        last;
    } t_meta;

    typedef struct packed {
        t_meta         meta;
        wfm_pkg::t_pix value;
    } t_res;

    function automatic logic [wfm_pkg::COL_W-1:0] col_last_of(
            input logic [wfm_pkg::SIZE_W-1:0] v);
        if (v < wfm_pkg::SIZE_W'(3)) begin
            return wfm_pkg::COL_W'(2);
        end else if (v > wfm_pkg::SIZE_W'(wfm_pkg::MAX_WIDTH)) begin
            return wfm_pkg::COL_W'(wfm_pkg::MAX_WIDTH - 1);
        end
        return wfm_pkg::COL_W'(v - wfm_pkg::SIZE_W'(1));
    endfunction

    function automatic logic [wfm_pkg::ROW_W-1:0] row_last_of(
            input logic [wfm_pkg::SIZE_W-1:0] v);
        if (v < wfm_pkg::SIZE_W'(3)) begin
            return wfm_pkg::ROW_W'(2);
        end else if (v > wfm_pkg::SIZE_W'(wfm_pkg::MAX_HEIGHT)) begin
            return wfm_pkg::ROW_W'(wfm_pkg::MAX_HEIGHT - 1);
        end
        return wfm_pkg::ROW_W'(v - wfm_pkg::SIZE_W'(1));
    endfunction

    // configuration
    wfm_pkg::t_mode                r_mode;
    logic [wfm_pkg::COL_W-1:0]     r_col_last;
    logic [wfm_pkg::ROW_W-1:0]     r_row_last;
    logic [wfm_pkg::DATA_W-1:0]    r_coef_lo, r_coef_mid;
    logic [wfm_pkg::COEF_W-1:0]    r_coef_hi;
    logic                          cfg_size_wr;

    // position of the next pixel
    logic [wfm_pkg::COL_W-1:0]     r_col, n_col;
    logic [wfm_pkg::ROW_W-1:0]     r_row, n_row;

    logic                          accept, emit;
    t_meta                         n_meta;

    // pipeline
    logic [LS_W-1:0]               ls_mem [wfm_pkg::MAX_WIDTH];
    logic [LS_W-1:0]               r_ls_rd;
    logic                          r_p1_valid, r_p1_emit;
    wfm_pkg::t_pix                 r_p1_pix;
    logic [wfm_pkg::COL_W-1:0]     r_p1_addr;
    t_meta                         r_p1_meta;
    logic                          r_p2_emit, r_pa_emit, r_pb_emit, r_pc_emit;
    t_meta                         r_p2_meta, r_pa_meta, r_pb_meta, r_pc_meta;

    wfm_pkg::t_col                 chain [4];
    wfm_pkg::t_win                 win;
    wfm_pkg::t_taps                taps;
    wfm_pkg::t_pix                 conv_value, med_value;

    // result queue
    t_res                          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]            r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]            r_cnt, r_pend;
    logic                          push, pop;
    t_res                          push_data, head;

    assign cfg_size_wr = i_cfg_we &&
        (wfm_pkg::t_cfg_idx'(i_cfg_idx) == wfm_pkg::CFG_IMAGE_WIDTH ||
         wfm_pkg::t_cfg_idx'(i_cfg_idx) == wfm_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= wfm_pkg::MODE_CONVOLVE;
            r_col_last <= wfm_pkg::COL_W'(wfm_pkg::MAX_WIDTH - 1);
            r_row_last <= wfm_pkg::ROW_W'(wfm_pkg::MAX_HEIGHT - 1);
            r_coef_lo  <= wfm_pkg::COEF_WORD_RST;
            r_coef_mid <= wfm_pkg::COEF_WORD_RST;
            r_coef_hi  <= wfm_pkg::COEF_TAP_RST;
        end else if (i_cfg_we) begin
            unique case (wfm_pkg::t_cfg_idx'(i_cfg_idx))
                wfm_pkg::CFG_FILTER_MODE: begin
                    r_mode <= wfm_pkg::t_mode'(i_cfg_data[0]);
                end
                wfm_pkg::CFG_IMAGE_WIDTH: begin
                    r_col_last <= col_last_of(i_cfg_data[wfm_pkg::SIZE_W-1:0]);
                end
                wfm_pkg::CFG_IMAGE_HEIGHT: begin
                    r_row_last <= row_last_of(i_cfg_data[wfm_pkg::SIZE_W-1:0]);
                end
                wfm_pkg::CFG_COEF_LOW: begin
                    r_coef_lo <= i_cfg_data;
                end
                wfm_pkg::CFG_COEF_MID: begin
                    r_coef_mid <= i_cfg_data;
                end
                wfm_pkg::CFG_COEF_HIGH: begin
                    r_coef_hi <= i_cfg_data[wfm_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // position counters
    assign i_pix.ready = (r_pend < FIFO_CW'(FIFO_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;
    assign emit        = (r_row >= wfm_pkg::ROW_W'(2)) && (r_col >= wfm_pkg::COL_W'(2));

    always_comb begin
        n_meta.row  = wfm_pkg::COORD_W'(r_row - wfm_pkg::ROW_W'(1));
        n_meta.col  = wfm_pkg::COORD_W'(r_col - wfm_pkg::COL_W'(1));
        n_meta.last = (r_row == r_row_last) && (r_col == r_col_last);
        n_col = r_col + wfm_pkg::COL_W'(1);
        n_row = r_row;
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + wfm_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores: high byte is two rows up, low byte one row up
    always_ff @(posedge i_clk) begin
        r_ls_rd <= ls_mem[r_col];
        if (r_p1_valid) begin
            ls_mem[r_p1_addr] <= {r_ls_rd[wfm_pkg::PIX_W-1:0], r_p1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_pix  <= i_pix.pixel;
        r_p1_addr <= r_col;
        r_p1_meta <= n_meta;
        r_p2_meta <= r_p1_meta;
        r_pa_meta <= r_p2_meta;
        r_pb_meta <= r_pa_meta;
        r_pc_meta <= r_pb_meta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p1_emit  <= 1'b0;
            r_p2_emit  <= 1'b0;
            r_pa_emit  <= 1'b0;
            r_pb_emit  <= 1'b0;
            r_pc_emit  <= 1'b0;
        end else begin
            r_p1_valid <= accept;
            r_p1_emit  <= accept && emit;
            r_p2_emit  <= r_p1_emit;
            r_pa_emit  <= r_p2_emit;
            r_pb_emit  <= r_pa_emit;
            r_pc_emit  <= r_pb_emit;
        end
    end

    // window: new column enters the rightmost cell, older columns move left
    assign chain[3].top = r_ls_rd[LS_W-1:wfm_pkg::PIX_W];
    assign chain[3].mid = r_ls_rd[wfm_pkg::PIX_W-1:0];
    assign chain[3].bot = r_p1_pix;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        wfm_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_p1_valid),
            .i_col   (chain[g+1]),
            .o_col   (chain[g])
        );
        assign win[g]     = chain[g].top;
        assign win[3 + g] = chain[g].mid;
        assign win[6 + g] = chain[g].bot;
    end

    for (genvar k = 0; k < 4; k++) begin : g_tap
        assign taps[k]     = r_coef_lo[wfm_pkg::COEF_W*k +: wfm_pkg::COEF_W];
        assign taps[4 + k] = r_coef_mid[wfm_pkg::COEF_W*k +: wfm_pkg::COEF_W];
    end
    assign taps[8] = r_coef_hi;

    wfm_conv u_conv (
        .i_clk   (i_clk),
        .i_win   (win),
        .i_taps  (taps),
        .o_value (conv_value)
    );

    wfm_median u_median (
        .i_clk   (i_clk),
        .i_win   (win),
        .o_value (med_value)
    );

    // result queue
    assign push           = r_pc_emit;
    assign pop            = o_res.valid && o_res.ready;
    assign push_data.meta = r_pc_meta;
    assign push_data.value = (r_mode == wfm_pkg::MODE_MEDIAN) ? med_value : conv_value;
    assign head           = fifo_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            fifo_mem[r_wr_ptr] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_pend   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + FIFO_CW'(push) - FIFO_CW'(pop);
            // count every result owed, in flight or queued
            r_pend <= r_pend + FIFO_CW'(accept && emit) - FIFO_CW'(pop);
        end
    end

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.out_row    = head.meta.row;
    assign o_res.out_col    = head.meta.col;
    assign o_res.value      = head.value;
    assign o_res.frame_last = head.meta.last;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        wfm_pkg::t_pix pix;
        int unsigned   gap;
        bit            hold;
    } t_pix_req;

    typedef struct {
        logic [wfm_pkg::COORD_W-1:0] row;
        logic [wfm_pkg::COORD_W-1:0] col;
        wfm_pkg::t_pix               value;
        logic                        last;
    } t_centre;

    logic i_clk;
    logic i_rst_n;
    logic                       cfg_we;
    logic [2:0]                 cfg_idx;
    logic [wfm_pkg::DATA_W-1:0] cfg_data;

    wfm_pixel_if  pix();
    wfm_result_if res();

    window_filter_median_or_convolve dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    // filter state as the block should hold it
    wfm_pkg::t_mode              filt_mode;
    logic [wfm_pkg::SIZE_W-1:0]  width_reg;
    logic [wfm_pkg::SIZE_W-1:0]  height_reg;
    logic [wfm_pkg::DATA_W-1:0]  taps_lo;
    logic [wfm_pkg::DATA_W-1:0]  taps_mid;
    logic [wfm_pkg::COEF_W-1:0]  tap_last;
    wfm_pkg::t_pix               line_up1 [wfm_pkg::MAX_WIDTH];
    wfm_pkg::t_pix               line_up2 [wfm_pkg::MAX_WIDTH];
    wfm_pkg::t_pix               win [wfm_pkg::TAPS];
    int                          row_at;
    int                          col_at;

    t_pix_req    pixel_q[$];
    t_centre     centre_q[$];
    int unsigned pixels_queued;
    int unsigned pixels_taken;
    int unsigned mismatches;
    int          src_gap_pct;
    int          snk_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("** window_filter_median_or_convolve: FAILED **");
        $finish;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int frame_dim(input logic [wfm_pkg::SIZE_W-1:0] v, input int maxv);
        if (v < 3)
            return 3;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic wfm_pkg::t_pix window_median();
        int below;
        int same;
        for (int i = 0; i < wfm_pkg::TAPS; i++) begin
            below = 0;
            same  = 0;
            for (int j = 0; j < wfm_pkg::TAPS; j++) begin
                if (win[j] < win[i])
                    below++;
                else if (win[j] == win[i])
                    same++;
            end
            // fifth smallest: at most four strictly below, at least five at or below
            if (below <= 4 && below + same >= 5)
                return win[i];
        end
        return '0;
    endfunction

    function automatic wfm_pkg::t_pix window_convolve();
        longint             acc;
        logic signed [15:0] k;
        acc = 0;
        for (int i = 0; i < wfm_pkg::TAPS; i++) begin
            if (i < 4)
                k = taps_lo[16*i +: 16];
            else if (i < 8)
                k = taps_mid[16*(i-4) +: 16];
            else
                k = tap_last;
            acc += longint'(win[i]) * longint'(k);
        end
        if (acc < 0)
            return '0;
        acc = acc >>> wfm_pkg::COEF_FRAC_BITS;
        return (acc > 255) ? 8'hFF : wfm_pkg::t_pix'(acc);
    endfunction

    task automatic filter_accept_pixel(input wfm_pkg::t_pix px);
        int      w;
        int      h;
        int      r;
        int      c;
        t_centre next_centre;
        w = frame_dim(width_reg, wfm_pkg::MAX_WIDTH);
        h = frame_dim(height_reg, wfm_pkg::MAX_HEIGHT);
        r = (row_at >= h) ? 0 : row_at;
        c = (col_at >= w) ? 0 : col_at;

        win[0] = win[1]; win[1] = win[2];
        win[3] = win[4]; win[4] = win[5];
        win[6] = win[7]; win[7] = win[8];
        win[2] = line_up2[c];
        win[5] = line_up1[c];
        win[8] = px;
        line_up2[c] = line_up1[c];
        line_up1[c] = px;

        if (r >= 2 && c >= 2) begin
            next_centre.row   = wfm_pkg::COORD_W'(r - 1);
            next_centre.col   = wfm_pkg::COORD_W'(c - 1);
            next_centre.value = (filt_mode == wfm_pkg::MODE_MEDIAN) ? window_median()
                                                                    : window_convolve();
            next_centre.last  = (r == h - 1 && c == w - 1);
            centre_q.push_back(next_centre);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    always @(posedge i_clk) begin : pixel_driver
        t_pix_req    req;
        int unsigned idle_left;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            idle_left = 0;
        end else begin
            if (pix.valid && pix.ready) begin
                filter_accept_pixel(pix.pixel);
                pixels_taken++;
            end
            if (!pix.valid || pix.ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    pix.valid <= 1'b0;
                end else if (pixel_q.size() > 0 &&
                             !(pixel_q[0].hold && centre_q.size() != 0)) begin
                    req = pixel_q.pop_front();
                    pix.valid <= 1'b1;
                    pix.pixel <= req.pix;
                    idle_left = req.gap;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_centre want;
        int      stall_left;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res.valid && res.ready) begin
                if (centre_q.size() == 0) begin
                    $error("result with none pending: row %0d col %0d value %0d",
                           res.out_row, res.out_col, res.value);
                    mismatches++;
                end else begin
                    want = centre_q.pop_front();
                    if (res.out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, res.out_row);
                        mismatches++;
                    end
                    if (res.out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, res.out_col);
                        mismatches++;
                    end
                    if (res.value !== want.value) begin
                        $error("value: expected %0d, got %0d (row %0d col %0d)",
                               want.value, res.value, want.row, want.col);
                        mismatches++;
                    end
                    if (res.frame_last !== want.last) begin
                        $error("frame_last: expected %0d, got %0d (row %0d col %0d)",
                               want.last, res.frame_last, want.row, want.col);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_stall_pct) begin
                stall_left = gap_len() - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input wfm_pkg::t_cfg_idx idx,
                             input logic [wfm_pkg::DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            wfm_pkg::CFG_FILTER_MODE:  filt_mode = wfm_pkg::t_mode'(data[0]);
            wfm_pkg::CFG_IMAGE_WIDTH: begin
                width_reg = data[wfm_pkg::SIZE_W-1:0];
                row_at = 0;
                col_at = 0;
            end
            wfm_pkg::CFG_IMAGE_HEIGHT: begin
                height_reg = data[wfm_pkg::SIZE_W-1:0];
                row_at = 0;
                col_at = 0;
            end
            wfm_pkg::CFG_COEF_LOW:     taps_lo  = data;
            wfm_pkg::CFG_COEF_MID:     taps_mid = data;
            wfm_pkg::CFG_COEF_HIGH:    tap_last = data[wfm_pkg::COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_taps(input logic [wfm_pkg::COEF_W-1:0] t [wfm_pkg::TAPS]);
        write_reg(wfm_pkg::CFG_COEF_LOW,  {t[3], t[2], t[1], t[0]});
        write_reg(wfm_pkg::CFG_COEF_MID,  {t[7], t[6], t[5], t[4]});
        write_reg(wfm_pkg::CFG_COEF_HIGH,
                  {{(wfm_pkg::DATA_W-wfm_pkg::COEF_W){1'b0}}, t[8]});
    endtask

    task automatic queue_pixel(input wfm_pkg::t_pix p, input bit hold);
        t_pix_req req;
        req.pix  = p;
        req.hold = hold;
        req.gap  = ($urandom_range(0, 99) < src_gap_pct) ? gap_len() : 0;
        pixel_q.push_back(req);
        pixels_queued++;
    endtask

    // hold until every request is taken and every centre is out, then let the
    // pipeline settle so that border requests have left it too
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || centre_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [wfm_pkg::COEF_W-1:0] pick_tap(input int kind, input int pos);
        case (kind)
            0: return wfm_pkg::COEF_W'($urandom_range(0, 65535));
            1: return wfm_pkg::COEF_W'($urandom_range(0, 1024));
            2: return (pos == 4) ? 16'h1000 : 16'h0000;
            3: return (pos == 4) ? 16'h5000 : 16'hF000;
            default: begin
                case ($urandom_range(0, 2))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic wfm_pkg::t_pix pick_pixel(input int pattern, input int k);
        case (pattern)
            0: return wfm_pkg::t_pix'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? wfm_pkg::t_pix'($urandom_range(250, 255))
                                          : wfm_pkg::t_pix'($urandom_range(0, 5));
            default: return wfm_pkg::t_pix'(k * 7 + $urandom_range(0, 15));
        endcase
    endfunction

    task automatic random_taps();
        logic [wfm_pkg::COEF_W-1:0] t [wfm_pkg::TAPS];
        int                         kind;
        kind = $urandom_range(0, 4);
        for (int i = 0; i < wfm_pkg::TAPS; i++)
            t[i] = pick_tap(kind, i);
        write_taps(t);
    endtask

    task automatic random_phase(input bit force_hold);
        int pcts [4];
        int n;
        int pattern;
        int hold_at;
        int sel;
        pcts = '{0, 0, 15, 40};
        src_gap_pct   = pcts[$urandom_range(0, 3)];
        snk_stall_pct = pcts[$urandom_range(0, 3)];

        if ($urandom_range(0, 1))
            write_reg(wfm_pkg::CFG_FILTER_MODE,
                      wfm_pkg::DATA_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 7) begin
            sel = $urandom_range(0, 9);
            write_reg(wfm_pkg::CFG_IMAGE_WIDTH,
                      wfm_pkg::DATA_W'((sel < 7) ? $urandom_range(3, 10) :
                                       (sel < 8) ? $urandom_range(0, 2) :
                                                   $urandom_range(11, 40)));
        end
        if ($urandom_range(0, 9) < 7) begin
            sel = $urandom_range(0, 19);
            write_reg(wfm_pkg::CFG_IMAGE_HEIGHT,
                      wfm_pkg::DATA_W'((sel < 14) ? $urandom_range(3, 8) :
                                       (sel < 17) ? $urandom_range(0, 2) :
                                                    $urandom_range(9, 20)));
        end
        if ($urandom_range(0, 1))
            random_taps();
        end_writes();

        n       = $urandom_range(35, 55);
        pattern = $urandom_range(0, 2);
        hold_at = (force_hold || $urandom_range(0, 9) < 3) ? $urandom_range(1, n - 1) : -1;
        for (int k = 0; k < n; k++)
            queue_pixel(pick_pixel(pattern, k), k == hold_at);
        wait_idle();
    endtask

    initial begin
        logic [wfm_pkg::COEF_W-1:0] t [wfm_pkg::TAPS];
        wfm_pkg::t_pix              mixed [wfm_pkg::TAPS];

        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        res.ready = 1'b0;

        filt_mode  = wfm_pkg::MODE_CONVOLVE;
        width_reg  = wfm_pkg::SIZE_W'(wfm_pkg::MAX_WIDTH);
        height_reg = wfm_pkg::SIZE_W'(wfm_pkg::MAX_HEIGHT);
        taps_lo    = wfm_pkg::COEF_WORD_RST;
        taps_mid   = wfm_pkg::COEF_WORD_RST;
        tap_last   = wfm_pkg::COEF_TAP_RST;
        row_at     = 0;
        col_at     = 0;
        for (int i = 0; i < wfm_pkg::TAPS; i++)
            win[i] = '0;
        for (int i = 0; i < wfm_pkg::MAX_WIDTH; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        pixels_queued = 0;
        pixels_taken  = 0;
        mismatches    = 0;
        src_gap_pct   = 0;
        snk_stall_pct = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // undersized frame acts as 3x3: one centre, saturating high
        write_reg(wfm_pkg::CFG_FILTER_MODE, wfm_pkg::DATA_W'(wfm_pkg::MODE_CONVOLVE));
        write_reg(wfm_pkg::CFG_IMAGE_WIDTH, wfm_pkg::DATA_W'(0));
        write_reg(wfm_pkg::CFG_IMAGE_HEIGHT, wfm_pkg::DATA_W'(2));
        for (int i = 0; i < wfm_pkg::TAPS; i++)
            t[i] = 16'h7FFF;
        write_taps(t);
        end_writes();
        for (int k = 0; k < wfm_pkg::TAPS; k++)
            queue_pixel(8'hFF, 1'b0);
        wait_idle();

        // most negative taps: negative sum floors to zero
        for (int i = 0; i < wfm_pkg::TAPS; i++)
            t[i] = 16'h8000;
        write_taps(t);
        end_writes();
        for (int k = 0; k < wfm_pkg::TAPS; k++)
            queue_pixel(8'hFF, 1'b0);
        wait_idle();

        write_reg(wfm_pkg::CFG_FILTER_MODE, wfm_pkg::DATA_W'(wfm_pkg::MODE_MEDIAN));
        end_writes();
        mixed = '{8'd0, 8'd255, 8'd7, 8'd200, 8'd13, 8'd128, 8'd64, 8'd1, 8'd254};
        for (int k = 0; k < wfm_pkg::TAPS; k++)
            queue_pixel(mixed[k], 1'b0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
            random_phase(ph == 0);

        // oversized row clamps to the widest, height clamps up to three
        src_gap_pct   = 10;
        snk_stall_pct = 10;
        write_reg(wfm_pkg::CFG_FILTER_MODE, wfm_pkg::DATA_W'(wfm_pkg::MODE_MEDIAN));
        write_reg(wfm_pkg::CFG_IMAGE_WIDTH, wfm_pkg::DATA_W'(2047));
        write_reg(wfm_pkg::CFG_IMAGE_HEIGHT, wfm_pkg::DATA_W'(0));
        end_writes();
        for (int k = 0; k < 40; k++)
            queue_pixel(pick_pixel(0, k), 1'b0);
        wait_idle();

        // narrowest row, tallest frame
        write_reg(wfm_pkg::CFG_FILTER_MODE, wfm_pkg::DATA_W'(wfm_pkg::MODE_CONVOLVE));
        write_reg(wfm_pkg::CFG_IMAGE_WIDTH, wfm_pkg::DATA_W'(1));
        write_reg(wfm_pkg::CFG_IMAGE_HEIGHT, wfm_pkg::DATA_W'(2047));
        random_taps();
        end_writes();
        for (int k = 0; k < 60; k++)
            queue_pixel(pick_pixel(k % 3, k), 1'b0);
        wait_idle();

        random_phase(1'b0);

        if (mismatches == 0)
            $display("** window_filter_median_or_convolve: PASSED **");
        else
            $display("** window_filter_median_or_convolve: FAILED **");
        $finish;
    end

endmodule
